// File: hw/rtl/fpst_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// fpst_pkg
// Shared types and constants of the frame-slot PRB/UE schedule table.
// ============================================================================
`default_nettype none

package fpst_pkg;

    localparam int MAX_UES   = 8;
    localparam int UE_W      = 3;
    localparam int MCS_W     = 5;
    localparam int PRB_W     = 5;
    localparam int FN_W      = 32;
    localparam int BMAP_W    = 32;
    localparam int OP_W      = 3;
    localparam int CNT_W     = 4;
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = FN_W / DIV_BITS;
    localparam int MCS_ENT_W = 2 * MCS_W;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
    localparam logic [OP_W-1:0] OP_BIT    = 3'd1;
    localparam logic [OP_W-1:0] OP_MAP    = 3'd2;
    localparam logic [OP_W-1:0] OP_LIST   = 3'd3;
    localparam logic [OP_W-1:0] OP_MCS    = 3'd4;
    localparam logic [OP_W-1:0] OP_REINIT = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_UE_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_UL_MCS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_DL_MCS   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [FN_W-1:0]   frame_number;
        logic [PRB_W-1:0]  prb_index;
        logic [UE_W-1:0]   ue_index;
        logic [BMAP_W-1:0] prb_bitmap;
        logic [MCS_W-1:0]  uplink_mcs;
        logic [MCS_W-1:0]  downlink_mcs;
    } t_req;

    typedef struct packed {
        logic               scheduled;
        logic [MAX_UES-1:0] ue_map;
        logic [UE_W-1:0]    listed_ue;
        logic               list_empty;
        logic [MCS_W-1:0]   ul_mcs_out;
        logic [MCS_W-1:0]   dl_mcs_out;
        logic               error;
        logic               last;
    } t_rsp;

    typedef struct packed {
        logic [CNT_W-1:0] ue_count;
        logic [CNT_W-1:0] stream_count;
        logic [MCS_W-1:0] default_ul_mcs;
        logic [MCS_W-1:0] default_dl_mcs;
    } t_cfg;

    localparam t_cfg CFG_RST = '{
        ue_count:       4'd8,
        stream_count:   4'd4,
        default_ul_mcs: 5'd10,
        default_dl_mcs: 5'd10
    };

    typedef struct packed {
        logic load;
        logic div_step;
        logic exec;
        logic list_step;
        logic fill_step;
        logic fill_default;
        logic fill_emit;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            map_empty;
        logic            list_last;
        logic            fill_last;
    } t_sts;

endpackage

`default_nettype wire

// File: hw/rtl/fpst_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// fpst_ram
// Single-port RAM with registered read data (read before write).
// ============================================================================
`default_nettype none

module fpst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/fpst_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// fpst_ctrl
// Sequencer: table fill sweep, slot reduction, table read, result issue.
// ============================================================================
`default_nettype none

module fpst_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire fpst_pkg::t_sts i_sts,
    output fpst_pkg::t_cmd     o_cmd,
    output logic               o_busy
);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_FILL_RST = 3'd0;
    localparam logic [ST_W-1:0] S_IDLE     = 3'd1;
    localparam logic [ST_W-1:0] S_DIV      = 3'd2;
    localparam logic [ST_W-1:0] S_READ     = 3'd3;
    localparam logic [ST_W-1:0] S_EXEC     = 3'd4;
    localparam logic [ST_W-1:0] S_LIST     = 3'd5;
    localparam logic [ST_W-1:0] S_FILL_OP  = 3'd6;

    localparam int DC_W = (fpst_pkg::DIV_STEPS > 1) ? $clog2(fpst_pkg::DIV_STEPS) : 1;

    logic [ST_W-1:0] r_state, n_state;
    logic [DC_W-1:0] r_div_cnt, n_div_cnt;

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        case (r_state)
            S_FILL_RST: begin
                o_cmd.fill_step    = 1'b1;
                o_cmd.fill_default = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_div_cnt  = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + DC_W'(1);
                if (r_div_cnt == DC_W'(fpst_pkg::DIV_STEPS - 1)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.op == fpst_pkg::OP_REINIT) begin
                    n_state = S_FILL_OP;
                end else begin
                    o_cmd.exec = 1'b1;
                    if (i_sts.op == fpst_pkg::OP_LIST && !i_sts.map_empty
                            && !i_sts.list_last) begin
                        n_state = S_LIST;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_LIST: begin
                o_cmd.list_step = 1'b1;
                if (i_sts.list_last) begin
                    n_state = S_IDLE;
                end
            end
            S_FILL_OP: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_last) begin
                    o_cmd.fill_emit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FILL_RST;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: hw/rtl/fpst_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// fpst_dp
// Datapath: slot reduction, schedule and MCS tables, list walk, result register.
// ============================================================================
`default_nettype none

module fpst_dp #(
    parameter int GROUPS = 40,
    parameter int PRBS   = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire fpst_pkg::t_req i_req,
    input  wire fpst_pkg::t_cfg i_cfg,
    input  wire fpst_pkg::t_cmd i_cmd,
    output fpst_pkg::t_sts     o_sts,
    output logic               o_valid,
    output fpst_pkg::t_rsp     o_rsp
);

    localparam int UES    = fpst_pkg::MAX_UES;
    localparam int UE_W   = fpst_pkg::UE_W;
    localparam int CNT_W  = fpst_pkg::CNT_W;
    localparam int ENT_W  = fpst_pkg::MCS_ENT_W;
    localparam int FN_W   = fpst_pkg::FN_W;
    localparam int DBITS  = fpst_pkg::DIV_BITS;
    localparam int AW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int RW     = $clog2(GROUPS + 1) + 1;
    localparam int SROW_W = PRBS * UES;
    localparam int MROW_W = UES * ENT_W;

    fpst_pkg::t_req r_req;
    fpst_pkg::t_rsp r_rsp, n_rsp;
    logic           r_valid, n_valid;
    logic [FN_W-1:0] r_fn;
    logic [RW-1:0]   r_rem, div_rem, div_t;
    logic [AW-1:0]   r_sweep;
    logic [UE_W-1:0] r_rr;
    logic [UES-1:0]  r_list;

    fpst_pkg::t_cfg  cfg_sel;
    logic [CNT_W-1:0] n_act, s_eff, rr4, lane_d;
    logic [UES-1:0]   ue_mask, fill_mask, cur_raw, cur_map, src_map, pick_oh, rest;
    logic [UE_W-1:0]  pick_idx;
    logic             ue_ok, on_p, fill_last, we;
    logic [AW-1:0]    addr;
    logic [SROW_W-1:0] sched_rd, sched_new, sched_wr;
    logic [MROW_W-1:0] mcs_rd, mcs_new, mcs_wr;
    logic [ENT_W-1:0]  mcs_ent;

    fpst_ram #(.WIDTH(SROW_W), .DEPTH(GROUPS)) u_sched_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(sched_wr),
        .o_rdata(sched_rd)
    );

    fpst_ram #(.WIDTH(MROW_W), .DEPTH(GROUPS)) u_mcs_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(mcs_wr),
        .o_rdata(mcs_rd)
    );

    always_comb begin
        cfg_sel = i_cmd.fill_default ? fpst_pkg::CFG_RST : i_cfg;
        if (cfg_sel.ue_count == '0) begin
            n_act = CNT_W'(1);
        end else if (cfg_sel.ue_count > CNT_W'(UES)) begin
            n_act = CNT_W'(UES);
        end else begin
            n_act = cfg_sel.ue_count;
        end
        s_eff   = (cfg_sel.stream_count > n_act) ? n_act : cfg_sel.stream_count;
        ue_mask = ~({UES{1'b1}} << n_act);
        ue_ok   = {1'b0, r_req.ue_index} < n_act;
    end

    // round-robin window of s_eff UEs starting at slot mod n_act
    always_comb begin
        rr4       = {1'b0, r_rr};
        lane_d    = '0;
        fill_mask = '0;
        for (int u = 0; u < UES; u++) begin
            if (CNT_W'(u) >= rr4) begin
                lane_d = CNT_W'(u) - rr4;
            end else begin
                lane_d = CNT_W'(u) + n_act - rr4;
            end
            fill_mask[u] = (CNT_W'(u) < n_act) && (lane_d < s_eff);
        end
    end

    // frame number mod GROUPS, DBITS bits per step
    always_comb begin
        div_rem = r_rem;
        div_t   = '0;
        for (int b = 0; b < DBITS; b++) begin
            div_t = {div_rem[RW-2:0], r_fn[FN_W-1-b]};
            if (div_t >= RW'(GROUPS)) begin
                div_rem = div_t - RW'(GROUPS);
            end else begin
                div_rem = div_t;
            end
        end
    end

    assign fill_last = (r_sweep == AW'(GROUPS - 1));
    assign addr      = i_cmd.fill_step ? r_sweep : r_rem[AW-1:0];

    always_comb begin
        cur_raw = '0;
        for (int p = 0; p < PRBS; p++) begin
            if (p < fpst_pkg::BMAP_W && r_req.prb_index == fpst_pkg::PRB_W'(p)) begin
                cur_raw = sched_rd[p*UES +: UES];
            end
        end
        cur_map = cur_raw & ue_mask;
        src_map = i_cmd.list_step ? r_list : cur_map;
        pick_idx = '0;
        for (int u = UES - 1; u >= 0; u--) begin
            if (src_map[u]) begin
                pick_idx = UE_W'(u);
            end
        end
        pick_oh = UES'(1) << pick_idx;
        rest    = src_map & ~pick_oh;
    end

    always_comb begin
        on_p      = 1'b0;
        sched_new = sched_rd;
        for (int p = 0; p < PRBS; p++) begin
            if (p < fpst_pkg::BMAP_W) begin
                on_p = r_req.prb_bitmap[fpst_pkg::PRB_W'(p)];
            end else begin
                on_p = 1'b0;
            end
            for (int u = 0; u < UES; u++) begin
                if (UE_W'(u) == r_req.ue_index) begin
                    sched_new[p*UES + u] = on_p;
                end
            end
        end
        mcs_new = mcs_rd;
        mcs_ent = '0;
        for (int u = 0; u < UES; u++) begin
            if (UE_W'(u) == r_req.ue_index) begin
                mcs_new[u*ENT_W +: ENT_W] = {r_req.downlink_mcs, r_req.uplink_mcs};
                mcs_ent = mcs_rd[u*ENT_W +: ENT_W];
            end
        end
    end

    always_comb begin
        we = i_cmd.fill_step
            | (i_cmd.exec && r_req.op == fpst_pkg::OP_WRITE && ue_ok);
        if (i_cmd.fill_step) begin
            sched_wr = {PRBS{fill_mask}};
            mcs_wr   = {UES{cfg_sel.default_dl_mcs, cfg_sel.default_ul_mcs}};
        end else begin
            sched_wr = sched_new;
            mcs_wr   = mcs_new;
        end
    end

    always_comb begin
        n_rsp   = '0;
        n_valid = 1'b0;
        if (i_cmd.exec) begin
            n_valid    = 1'b1;
            n_rsp.last = 1'b1;
            case (r_req.op)
                fpst_pkg::OP_WRITE: begin
                    n_rsp.error = !ue_ok;
                end
                fpst_pkg::OP_BIT: begin
                    n_rsp.error     = !ue_ok;
                    n_rsp.scheduled = ue_ok & cur_map[r_req.ue_index];
                end
                fpst_pkg::OP_MAP: begin
                    n_rsp.ue_map = cur_map;
                end
                fpst_pkg::OP_LIST: begin
                    if (cur_map == '0) begin
                        n_rsp.list_empty = 1'b1;
                    end else begin
                        n_rsp.listed_ue = pick_idx;
                        n_rsp.last      = (rest == '0);
                    end
                end
                fpst_pkg::OP_MCS: begin
                    n_rsp.error = !ue_ok;
                    if (ue_ok) begin
                        n_rsp.ul_mcs_out = mcs_ent[fpst_pkg::MCS_W-1:0];
                        n_rsp.dl_mcs_out = mcs_ent[ENT_W-1:fpst_pkg::MCS_W];
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.list_step) begin
            n_valid         = 1'b1;
            n_rsp.listed_ue = pick_idx;
            n_rsp.last      = (rest == '0);
        end else if (i_cmd.fill_emit) begin
            n_valid    = 1'b1;
            n_rsp.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sweep <= '0;
            r_rr    <= '0;
        end else begin
            r_valid <= n_valid;
            if (i_cmd.fill_step) begin
                if (fill_last) begin
                    r_sweep <= '0;
                    r_rr    <= '0;
                end else begin
                    r_sweep <= r_sweep + AW'(1);
                    if (rr4 + CNT_W'(1) == n_act) begin
                        r_rr <= '0;
                    end else begin
                        r_rr <= r_rr + UE_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (i_cmd.load) begin
            r_req <= i_req;
            r_fn  <= i_req.frame_number;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_rem;
            r_fn  <= r_fn << DBITS;
        end
        if (i_cmd.exec || i_cmd.list_step) begin
            r_list <= rest;
        end
    end

    assign o_sts.op        = r_req.op;
    assign o_sts.map_empty = (cur_map == '0);
    assign o_sts.list_last = (rest == '0);
    assign o_sts.fill_last = fill_last;

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

// File: hw/rtl/frame_prb_ue_schedule_table_top.sv
`timescale 1ns / 1ps
// ============================================================================
// frame_prb_ue_schedule_table_top
// Per-frame-slot PRB/UE schedule table with APB configuration registers.
// ============================================================================
// A request is taken when start is high and busy is low. Its frame number is
// reduced to a slot 8 bits per cycle, the slot's table row is then read from
// the registered RAM and the first result is issued, so a single-result
// request has its result shown in the same cycle in which busy falls. A list
// query issues one result per listed UE. A reinit request adds one table write
// per slot before its single result. After reset the block sweeps all GROUPS
// slots with busy high before it takes a request. Results are shown for one
// cycle with o_valid and cannot be held off by the receiver.
// ============================================================================
`default_nettype none

module frame_prb_ue_schedule_table_top #(
    parameter int GROUPS = 40,
    parameter int PRBS   = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire fpst_pkg::t_req                    i_req,
    output logic                                   o_valid,
    output fpst_pkg::t_rsp                         o_rsp,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [fpst_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [fpst_pkg::PDATA_W-1:0]      pwdata,
    output logic      [fpst_pkg::PDATA_W-1:0]      prdata,
    output logic                                   pready
);

    localparam int PDW = fpst_pkg::PDATA_W;

    fpst_pkg::t_cfg r_cfg;
    fpst_pkg::t_cmd cmd;
    fpst_pkg::t_sts sts;
    logic           cfg_wr;
    logic [fpst_pkg::CFG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[fpst_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= fpst_pkg::CFG_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                fpst_pkg::CFG_UE_COUNT:     r_cfg.ue_count <= pwdata[fpst_pkg::CNT_W-1:0];
                fpst_pkg::CFG_STREAM_COUNT: r_cfg.stream_count <= pwdata[fpst_pkg::CNT_W-1:0];
                fpst_pkg::CFG_DEF_UL_MCS:   r_cfg.default_ul_mcs <= pwdata[fpst_pkg::MCS_W-1:0];
                fpst_pkg::CFG_DEF_DL_MCS:   r_cfg.default_dl_mcs <= pwdata[fpst_pkg::MCS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            fpst_pkg::CFG_UE_COUNT:     prdata = PDW'(r_cfg.ue_count);
            fpst_pkg::CFG_STREAM_COUNT: prdata = PDW'(r_cfg.stream_count);
            fpst_pkg::CFG_DEF_UL_MCS:   prdata = PDW'(r_cfg.default_ul_mcs);
            fpst_pkg::CFG_DEF_DL_MCS:   prdata = PDW'(r_cfg.default_dl_mcs);
            default:                    prdata = '0;
        endcase
    end

    fpst_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    fpst_dp #(.GROUPS(GROUPS), .PRBS(PRBS)) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req),
        .i_cfg  (r_cfg),
        .i_cmd  (cmd),
        .o_sts  (sts),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request taken but block not busy");

    a_list_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.last |=> o_valid)
        else $error("gap inside a multi-result request");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.list_empty |-> o_rsp.last)
        else $error("empty list result without last");

    a_valid_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result issued while idle");

endmodule

`default_nettype wire
